### hdl/tss_pkg.sv
// Shared types, codes and defaults of the thread scheduler.
package tss_pkg;

   // Default sizes
   localparam int TSS_NUM_THREADS    = 6;
   localparam int TSS_NUM_SEMAPHORES = 8;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int SID_W    = 3;
   localparam int SLEEP_W  = 32;
   localparam int SEM_W    = 16;
   localparam int THREAD_W = 3;
   localparam int FIRE_W   = 2;
   localparam int CSR_AW   = 8;
   localparam int CSR_DW   = 32;
   localparam int TIMER_W  = 32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SWITCH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WAIT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SIGNAL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_INIT   = 3'd5;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_EV0_ENABLE = 8'd0;
   localparam logic [CSR_AW-1:0] CSR_EV0_PERIOD = 8'd1;
   localparam logic [CSR_AW-1:0] CSR_EV1_ENABLE = 8'd2;
   localparam logic [CSR_AW-1:0] CSR_EV1_PERIOD = 8'd3;

   // Semaphore saturation limits
   localparam logic signed [SEM_W-1:0] SEM_MAX = 16'sh7FFF;
   localparam logic signed [SEM_W-1:0] SEM_MIN = 16'sh8000;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [SID_W-1:0]        sema_id;
      logic [SLEEP_W-1:0]      sleep_ms;
      logic signed [SEM_W-1:0] init_value;
   } tss_req_type;

   typedef struct packed {
      logic [THREAD_W-1:0]     current_thread;
      logic [FIRE_W-1:0]       event_fire;
      logic signed [SEM_W-1:0] sema_value;
      logic                    woke;
      logic [THREAD_W-1:0]     woken_thread;
      logic                    no_ready_thread;
   } tss_res_type;

   typedef struct packed {
      logic [1:0]              ev_enable;
      logic [1:0][TIMER_W-1:0] ev_period;
   } tss_cfg_type;

   // Results of the shared step unit
   typedef struct packed {
      logic                    sleep_zero;
      logic [SLEEP_W-1:0]      sleep_dec;
      logic                    tmr_fire;
      logic [TIMER_W-1:0]      tmr_next;
      logic signed [SEM_W-1:0] sem_next;
   } tss_step_type;

endpackage

### hdl/tss_ifs.sv
// Handshake channel interfaces of the thread scheduler.
interface tss_req_if;
   import tss_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [SID_W-1:0]        sema_id;
   logic [SLEEP_W-1:0]      sleep_ms;
   logic signed [SEM_W-1:0] init_value;
   modport source (output valid, cmd, sema_id, sleep_ms, init_value, input ready);
   modport sink (input valid, cmd, sema_id, sleep_ms, init_value, output ready);
endinterface

interface tss_rsp_if;
   import tss_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [THREAD_W-1:0]     current_thread;
   logic [FIRE_W-1:0]       event_fire;
   logic signed [SEM_W-1:0] sema_value;
   logic                    woke;
   logic [THREAD_W-1:0]     woken_thread;
   logic                    no_ready_thread;
   modport source (output valid, current_thread, event_fire, sema_value, woke,
                   woken_thread, no_ready_thread, input ready);
   modport sink (input valid, current_thread, event_fire, sema_value, woke,
                 woken_thread, no_ready_thread, output ready);
endinterface

interface tss_csr_if;
   import tss_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] index;
   logic [CSR_DW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/thread_scheduler_with_semaphores.sv
// Top level of the round-robin thread scheduler with counting semaphores.
//
//  channel  dir  handshake          payload
//  req      in   valid / ready      cmd, sema_id, sleep_ms, init_value
//  rsp      out  valid / ready      current_thread, event_fire, sema_value,
//                                   woke, woken_thread, no_ready_thread
//  csr      in   valid / ready (1)  index, data
//
// One item at a time; the sequencer walks one thread entry per cycle through
// the shared step unit. Tick walks every entry, switch and sleep search the
// ring for a ready thread, wait and signal first update the semaphore value
// from the bank's registered read port and may then search or wake, and init
// and unused codes go straight to the result, which enters the output register.
// Reset is synchronous and clears all threads, timers and semaphores at once.
// The output register lets the next item in while a result waits on rsp.
module thread_scheduler_with_semaphores #(
   parameter int NUM_THREADS    = tss_pkg::TSS_NUM_THREADS,
   parameter int NUM_SEMAPHORES = tss_pkg::TSS_NUM_SEMAPHORES
) (
   input logic        clock,
   input logic        reset,
   tss_req_if.sink    req,
   tss_rsp_if.source  rsp,
   tss_csr_if.sink    csr
);
   import tss_pkg::*;

   tss_cfg_type cfg_ff;
   tss_req_type core_req;
   tss_res_type core_res;
   tss_res_type rsp_data_ff;
   logic        rsp_valid_ff;
   logic        core_out_valid;
   logic        core_out_ready;
   logic        core_in_ready;

   // Write configuration registers; the port never stalls
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_EV0_ENABLE: cfg_ff.ev_enable[0] <= csr.data[0];
            CSR_EV0_PERIOD: cfg_ff.ev_period[0] <= TIMER_W'(csr.data);
            CSR_EV1_ENABLE: cfg_ff.ev_enable[1] <= csr.data[0];
            CSR_EV1_PERIOD: cfg_ff.ev_period[1] <= TIMER_W'(csr.data);
            default: begin
            end
         endcase
      end
   end

   // Gather the request item
   assign core_req.cmd        = req.cmd;
   assign core_req.sema_id    = req.sema_id;
   assign core_req.sleep_ms   = req.sleep_ms;
   assign core_req.init_value = req.init_value;
   assign req.ready           = core_in_ready;

   tss_core #(
      .NUM_THREADS    (NUM_THREADS),
      .NUM_SEMAPHORES (NUM_SEMAPHORES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .in_ready  (core_in_ready),
      .in_data   (core_req),
      .out_valid (core_out_valid),
      .out_ready (core_out_ready),
      .out_data  (core_res)
   );

   // Hold the result item until rsp takes it
   assign core_out_ready = !rsp_valid_ff || rsp.ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_out_ready) begin
         rsp_valid_ff <= core_out_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (core_out_ready && core_out_valid) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.current_thread  = rsp_data_ff.current_thread;
   assign rsp.event_fire      = rsp_data_ff.event_fire;
   assign rsp.sema_value      = rsp_data_ff.sema_value;
   assign rsp.woke            = rsp_data_ff.woke;
   assign rsp.woken_thread    = rsp_data_ff.woken_thread;
   assign rsp.no_ready_thread = rsp_data_ff.no_ready_thread;
endmodule

### hdl/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/tss_step_unit.sv
// Shared arithmetic unit: sleep countdown, event timer and semaphore update.
module tss_step_unit (
   input  logic [tss_pkg::SLEEP_W-1:0]      sleep_val,
   input  logic [tss_pkg::TIMER_W-1:0]      tmr_val,
   input  logic [tss_pkg::TIMER_W-1:0]      tmr_period,
   input  logic signed [tss_pkg::SEM_W-1:0] sem_val,
   input  logic                             sem_up,
   output tss_pkg::tss_step_type            step
);
   import tss_pkg::*;

   logic [TIMER_W-1:0] tmr_inc;

   // Count down one sleep entry
   assign step.sleep_zero = (sleep_val == '0);
   assign step.sleep_dec  = sleep_val - 1'b1;

   // Advance an event timer, fire and clear at the period
   assign tmr_inc        = tmr_val + 1'b1;
   assign step.tmr_fire  = (tmr_inc >= tmr_period);
   assign step.tmr_next  = step.tmr_fire ? '0 : tmr_inc;

   // Saturating semaphore increment or decrement
   assign step.sem_next = sem_up ?
      ((sem_val != SEM_MAX) ? sem_val + 16'sd1 : sem_val) :
      ((sem_val != SEM_MIN) ? sem_val - 16'sd1 : sem_val);
endmodule

### hdl/tss_core.sv
// Scheduler sequencer: thread table walk, event timers and semaphore bank.
module tss_core #(
   parameter int NUM_THREADS    = tss_pkg::TSS_NUM_THREADS,
   parameter int NUM_SEMAPHORES = tss_pkg::TSS_NUM_SEMAPHORES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::tss_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tss_pkg::tss_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tss_pkg::tss_res_type out_data
);
   import tss_pkg::*;

   localparam int TW     = $clog2(NUM_THREADS);
   localparam int SEM_AW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_TICK   = 6'b000010,
      S_SEMRD  = 6'b000100,
      S_SEARCH = 6'b001000,
      S_WAKE   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                state_ff;
   logic [CMD_W-1:0]         cmd_ff;
   logic [SID_W-1:0]         sid_ff;
   logic [TW-1:0]            pos_ff;
   logic [TW-1:0]            cnt_ff;
   logic [TW-1:0]            run_ff;
   logic [SLEEP_W-1:0]       sleep_ff [NUM_THREADS];
   logic [NUM_THREADS-1:0]   blk_ff;
   logic [SID_W-1:0]         bsem_ff [NUM_THREADS];
   logic [1:0][TIMER_W-1:0]  timer_ff;
   logic [NUM_SEMAPHORES-1:0] sem_vld_ff;
   logic                     sem_rd_vld_ff;
   tss_res_type              res_ff;

   logic                     accept;
   logic                     sid_ok;
   logic [SEM_AW-1:0]        in_sem_idx;
   logic [SEM_AW-1:0]        cur_sem_idx;
   logic                     cnt_last;
   logic                     ev_slot;
   logic [TW-1:0]            run_next;
   logic [TW-1:0]            pos_next;
   logic signed [SEM_W-1:0]  sem_old;
   logic [SEM_W-1:0]         ram_rd_data;
   logic                     ram_wr_en;
   logic [SEM_AW-1:0]        ram_wr_addr;
   logic [SEM_W-1:0]         ram_wr_data;
   tss_step_type             step;

   function automatic logic [TW-1:0] ring_next(input logic [TW-1:0] p);
      ring_next = (p == TW'(NUM_THREADS - 1)) ? '0 : p + 1'b1;
   endfunction

   // Decode the handshake and walk position
   assign in_ready    = (state_ff == S_IDLE);
   assign accept      = in_valid && in_ready;
   assign sid_ok      = (32'(in_data.sema_id) < 32'(NUM_SEMAPHORES));
   assign in_sem_idx  = SEM_AW'(in_data.sema_id);
   assign cur_sem_idx = SEM_AW'(sid_ff);
   assign cnt_last    = (cnt_ff == TW'(NUM_THREADS - 1));
   assign ev_slot     = (pos_ff == TW'(0)) || (pos_ff == TW'(1));
   assign run_next    = ring_next(run_ff);
   assign pos_next    = ring_next(pos_ff);
   assign sem_old     = sem_rd_vld_ff ? $signed(ram_rd_data) : '0;

   // Shared unit sees the walked entry
   tss_step_unit u_step (
      .sleep_val  (sleep_ff[pos_ff]),
      .tmr_val    (timer_ff[pos_ff[0]]),
      .tmr_period (cfg.ev_period[pos_ff[0]]),
      .sem_val    (sem_old),
      .sem_up     (cmd_ff == CMD_SIGNAL),
      .step       (step)
   );

   // Semaphore bank write port
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_sem_idx;
      ram_wr_data = $unsigned(step.sem_next);
      if (accept && (in_data.cmd == CMD_INIT) && sid_ok) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = in_sem_idx;
         ram_wr_data = $unsigned(in_data.init_value);
      end else if (state_ff == S_SEMRD) begin
         ram_wr_en   = 1'b1;
      end
   end

   tss_ram #(
      .WIDTH (SEM_W),
      .DEPTH (NUM_SEMAPHORES)
   ) u_sem_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (in_sem_idx),
      .rd_data (ram_rd_data)
   );

   // Sequence one command over the thread ring
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         run_ff     <= '0;
         blk_ff     <= '0;
         timer_ff   <= '0;
         sem_vld_ff <= '0;
         res_ff     <= '0;
         for (int i = 0; i < NUM_THREADS; i++) begin
            sleep_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff        <= in_data.cmd;
                  sid_ff        <= in_data.sema_id;
                  cnt_ff        <= '0;
                  pos_ff        <= (in_data.cmd == CMD_TICK) ? '0 : run_next;
                  sem_rd_vld_ff <= sem_vld_ff[in_sem_idx];
                  case (in_data.cmd)
                     CMD_TICK: begin
                        state_ff <= S_TICK;
                     end
                     CMD_SWITCH: begin
                        state_ff <= S_SEARCH;
                     end
                     CMD_SLEEP: begin
                        sleep_ff[run_ff] <= in_data.sleep_ms;
                        state_ff         <= S_SEARCH;
                     end
                     CMD_WAIT, CMD_SIGNAL: begin
                        state_ff <= sid_ok ? S_SEMRD : S_DONE;
                     end
                     CMD_INIT: begin
                        if (sid_ok) begin
                           sem_vld_ff[in_sem_idx] <= 1'b1;
                           res_ff.sema_value      <= in_data.init_value;
                        end
                        state_ff <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_TICK: begin
               // Count down this entry; the first two slots also run the timers
               if (!step.sleep_zero) begin
                  sleep_ff[pos_ff] <= step.sleep_dec;
               end
               if (ev_slot && cfg.ev_enable[pos_ff[0]]) begin
                  timer_ff[pos_ff[0]] <= step.tmr_next;
                  if (step.tmr_fire) begin
                     res_ff.event_fire[pos_ff[0]] <= 1'b1;
                  end
               end
               pos_ff <= pos_next;
               if (pos_ff == TW'(NUM_THREADS - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_SEMRD: begin
               sem_vld_ff[cur_sem_idx] <= 1'b1;
               res_ff.sema_value       <= step.sem_next;
               if (cmd_ff == CMD_WAIT) begin
                  if (step.sem_next < 0) begin
                     blk_ff[run_ff]  <= 1'b1;
                     bsem_ff[run_ff] <= sid_ff;
                     state_ff        <= S_SEARCH;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= (step.sem_next <= 0) ? S_WAKE : S_DONE;
               end
            end
            S_SEARCH: begin
               // Take the first thread neither asleep nor blocked
               if (step.sleep_zero && !blk_ff[pos_ff]) begin
                  run_ff   <= pos_ff;
                  state_ff <= S_DONE;
               end else if (cnt_last) begin
                  res_ff.no_ready_thread <= 1'b1;
                  state_ff               <= S_DONE;
               end else begin
                  pos_ff <= pos_next;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_WAKE: begin
               // Release the first waiter on this semaphore
               if (blk_ff[pos_ff] && (bsem_ff[pos_ff] == sid_ff)) begin
                  blk_ff[pos_ff]      <= 1'b0;
                  res_ff.woke         <= 1'b1;
                  res_ff.woken_thread <= THREAD_W'(pos_ff);
                  state_ff            <= S_DONE;
               end else if (cnt_last) begin
                  state_ff <= S_DONE;
               end else begin
                  pos_ff <= pos_next;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DONE: begin
               // Hand off the result and clear it for the next item
               if (out_ready) begin
                  res_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Present the finished item
   always_comb begin
      out_data                = res_ff;
      out_data.current_thread = THREAD_W'(run_ff);
   end
   assign out_valid = (state_ff == S_DONE);
endmodule

### tb/tss_sched_checker.sv
// Scoreboard for the thread scheduler: tracks its state, predicts every result and compares.
module tss_sched_checker (
   input  logic        clock,
   input  logic        reset,
   tss_req_if          req,
   tss_rsp_if          rsp,
   tss_csr_if          csr,
   output int unsigned fail_count,
   output int unsigned pending
);
   import tss_pkg::*;

   localparam int NT = TSS_NUM_THREADS;
   localparam int NS = TSS_NUM_SEMAPHORES;

   // Event configuration as last written
   bit                      ev_on[2];
   logic [TIMER_W-1:0]      ev_period[2];

   // Scheduler state
   logic [THREAD_W-1:0]     running;
   logic [SLEEP_W-1:0]      naps[NT];
   bit                      blocked[NT];
   logic [SID_W-1:0]        blocked_on[NT];
   logic signed [SEM_W-1:0] sems[NS];
   logic [TIMER_W-1:0]      ev_timer[2];

   tss_res_type             expected_outcomes[$];
   int unsigned             mismatches;

   assign fail_count = mismatches;

   // Move round-robin to the next thread that is awake and unblocked, running one last
   function automatic bit advance_ring();
      int t;
      bit found;
      found = 0;
      for (int k = 1; k <= NT; k++) begin
         t = (int'(running) + k) % NT;
         if (!found && naps[t] == 0 && !blocked[t]) begin
            running = t[THREAD_W-1:0];
            found = 1;
         end
      end
      return found;
   endfunction

   // Apply one command to the tracked state and return the result it must give
   function automatic tss_res_type schedule_step(tss_req_type c);
      tss_res_type r;
      int t;
      r = '0;
      case (c.cmd)
         CMD_TICK: begin
            for (int i = 0; i < 2; i++) begin
               if (ev_on[i]) begin
                  ev_timer[i] = ev_timer[i] + 1;
                  if (ev_timer[i] >= ev_period[i]) begin
                     r.event_fire[i] = 1'b1;
                     ev_timer[i] = '0;
                  end
               end
            end
            for (int i = 0; i < NT; i++)
               if (naps[i] != 0) naps[i] = naps[i] - 1;
         end
         CMD_SWITCH: r.no_ready_thread = !advance_ring();
         CMD_SLEEP: begin
            naps[running] = c.sleep_ms;
            r.no_ready_thread = !advance_ring();
         end
         CMD_WAIT: begin
            if (c.sema_id < NS) begin
               if (sems[c.sema_id] != SEM_MIN) sems[c.sema_id] = sems[c.sema_id] - 16'sd1;
               r.sema_value = sems[c.sema_id];
               if (sems[c.sema_id] < 0) begin
                  blocked[running]    = 1;
                  blocked_on[running] = c.sema_id;
                  r.no_ready_thread   = !advance_ring();
               end
            end
         end
         CMD_SIGNAL: begin
            if (c.sema_id < NS) begin
               if (sems[c.sema_id] != SEM_MAX) sems[c.sema_id] = sems[c.sema_id] + 16'sd1;
               r.sema_value = sems[c.sema_id];
               // release the first waiter after the running thread
               if (sems[c.sema_id] <= 0) begin
                  for (int k = 1; k <= NT; k++) begin
                     t = (int'(running) + k) % NT;
                     if (!r.woke && blocked[t] && blocked_on[t] == c.sema_id) begin
                        blocked[t]     = 0;
                        r.woke         = 1'b1;
                        r.woken_thread = t[THREAD_W-1:0];
                     end
                  end
               end
            end
         end
         CMD_INIT: begin
            if (c.sema_id < NS) begin
               sems[c.sema_id] = c.init_value;
               r.sema_value    = c.init_value;
            end
         end
         default: ;
      endcase
      r.current_thread = running;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
         mismatches++;
      end
   endfunction

   // Watch all three channels at each edge
   always @(posedge clock) begin : watch
      tss_req_type item;
      tss_res_type want;
      if (reset) begin
         running = '0;
         for (int i = 0; i < NT; i++) begin
            naps[i]       = '0;
            blocked[i]    = 0;
            blocked_on[i] = '0;
         end
         for (int i = 0; i < NS; i++) sems[i] = '0;
         for (int i = 0; i < 2; i++) begin
            ev_on[i]     = 0;
            ev_period[i] = '0;
            ev_timer[i]  = '0;
         end
         expected_outcomes.delete();
         mismatches = 0;
         pending <= 0;
      end else begin
         // latch register writes
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_EV0_ENABLE: ev_on[0]     = csr.data[0];
               CSR_EV0_PERIOD: ev_period[0] = csr.data;
               CSR_EV1_ENABLE: ev_on[1]     = csr.data[0];
               CSR_EV1_PERIOD: ev_period[1] = csr.data;
               default: ;
            endcase
         end
         // compare a delivered result with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result arrived with no item outstanding");
               mismatches++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("current_thread", want.current_thread, rsp.current_thread);
               check_field("event_fire", want.event_fire, rsp.event_fire);
               check_field("sema_value", want.sema_value, rsp.sema_value);
               check_field("woke", want.woke, rsp.woke);
               check_field("woken_thread", want.woken_thread, rsp.woken_thread);
               check_field("no_ready_thread", want.no_ready_thread, rsp.no_ready_thread);
            end
         end
         // predict for an accepted command
         if (req.valid && req.ready) begin
            item.cmd        = req.cmd;
            item.sema_id    = req.sema_id;
            item.sleep_ms   = req.sleep_ms;
            item.init_value = req.init_value;
            expected_outcomes.push_back(schedule_step(item));
         end
         pending <= expected_outcomes.size();
      end
   end

endmodule

### tb/tb_top.sv
// Top of the thread scheduler testbench: clock, reset, command stimulus and verdict.
module tb_top;
   import tss_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          HOLD_CYCLES  = 250;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          PHASE_ITEMS  = 170;
   localparam int          MAX_GAP      = 14;
   localparam logic [CMD_W-1:0]  CMD_SPARE_LO  = 3'd6;
   localparam logic [CMD_W-1:0]  CMD_SPARE_HI  = 3'd7;
   localparam logic [CSR_AW-1:0] CSR_UNMAPPED  = 8'd4;
   localparam logic [CSR_AW-1:0] CSR_LAST_ADDR = 8'hFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned cycles = 0;
   int          send_idle_pct = 60;
   int          recv_idle_pct = 60;
   bit          rsp_hold_req = 0;

   tss_req_if req_ch ();
   tss_rsp_if rsp_ch ();
   tss_csr_if csr_ch ();

   thread_scheduler_with_semaphores u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   tss_sched_checker u_sched_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_gap(int pct);
      if ($urandom_range(0, 99) < pct) return $urandom_range(1, MAX_GAP);
      return 0;
   endfunction

   function automatic tss_req_type make_cmd(logic [CMD_W-1:0] cmd, int id,
                                            logic [SLEEP_W-1:0] nap, int initv);
      tss_req_type it;
      it.cmd        = cmd;
      it.sema_id    = id[SID_W-1:0];
      it.sleep_ms   = nap;
      it.init_value = initv[SEM_W-1:0];
      return it;
   endfunction

   // Build a random command: mostly small sleeps and semaphore values, noise elsewhere
   function automatic tss_req_type random_cmd();
      tss_req_type it;
      int pick;
      int v;
      pick          = $urandom_range(0, 99);
      it.sema_id    = SID_W'($urandom_range(0, 7));
      it.sleep_ms   = $urandom;
      it.init_value = SEM_W'($urandom);
      if (pick < 28) it.cmd = CMD_TICK;
      else if (pick < 42) it.cmd = CMD_SWITCH;
      else if (pick < 52) begin
         it.cmd = CMD_SLEEP;
         if ($urandom_range(0, 9) < 8) it.sleep_ms = $urandom_range(0, 12);
         else it.sleep_ms = $urandom_range(13, 60);
      end
      else if (pick < 68) it.cmd = CMD_WAIT;
      else if (pick < 84) it.cmd = CMD_SIGNAL;
      else if (pick < 95) begin
         it.cmd = CMD_INIT;
         if ($urandom_range(0, 99) < 85) begin
            v = $urandom_range(0, 6);
            v = v - 3;
            it.init_value = v[SEM_W-1:0];
         end
      end
      else it.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      return it;
   endfunction

   // Offer one command and hold it until accepted; valid stays high afterwards
   task automatic send_item(tss_req_type it);
      int gap;
      gap = draw_gap(send_idle_pct);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= it.cmd;
      req_ch.sema_id    <= it.sema_id;
      req_ch.sleep_ms   <= it.sleep_ms;
      req_ch.init_value <= it.init_value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and wait until every predicted result has been delivered
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_events(logic [CSR_DW-1:0] en0, logic [CSR_DW-1:0] per0,
                                 logic [CSR_DW-1:0] en1, logic [CSR_DW-1:0] per1);
      write_reg(CSR_EV0_ENABLE, en0);
      write_reg(CSR_EV0_PERIOD, per0);
      write_reg(CSR_EV1_ENABLE, en1);
      write_reg(CSR_EV1_PERIOD, per1);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_random(int count, int hold_at, int pause_at);
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) rsp_hold_req = 1;
         if (n == pause_at) wait_idle();
         send_item(random_cmd());
      end
      wait_idle();
   endtask

   // Result side: random stalls plus one long hold when asked
   initial begin
      forever begin : drain_loop
         int gap;
         gap = draw_gap(recv_idle_pct);
         if (rsp_hold_req) begin
            rsp_hold_req = 0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Command side and verdict
   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= CMD_TICK;
      req_ch.sema_id    <= '0;
      req_ch.sleep_ms   <= '0;
      req_ch.init_value <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= CSR_EV0_ENABLE;
      csr_ch.data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fire event zero every tick, event one every second; poke unmapped indexes
      write_reg(CSR_UNMAPPED, $urandom);
      write_reg(CSR_LAST_ADDR, 32'hFFFF_FFFF);
      program_events(32'd1, 32'd0, 32'd1, 32'd2);

      // Directed: ticks, a switch, saturation at both ends, a signal with no waiter
      send_item(make_cmd(CMD_TICK, 0, 32'd0, 0));
      send_item(make_cmd(CMD_TICK, 7, 32'hFFFF_FFFF, -1));
      send_item(make_cmd(CMD_TICK, 3, 32'd5, 9));
      send_item(make_cmd(CMD_SWITCH, 0, 32'd0, 0));
      send_item(make_cmd(CMD_INIT, 0, 32'd0, 32767));
      send_item(make_cmd(CMD_SIGNAL, 0, 32'd0, 0));
      send_item(make_cmd(CMD_INIT, 7, 32'd0, -32768));
      send_item(make_cmd(CMD_WAIT, 7, 32'd0, 0));
      send_item(make_cmd(CMD_SIGNAL, 7, 32'd0, 0));
      send_item(make_cmd(CMD_INIT, 5, 32'd0, -1));
      send_item(make_cmd(CMD_SIGNAL, 5, 32'd0, 0));
      send_item(make_cmd(CMD_SLEEP, 2, 32'd0, 0));
      send_item(make_cmd(CMD_SLEEP, 2, 32'd3, 0));
      send_item(make_cmd(CMD_SPARE_LO, 6, 32'h1234_5678, 77));
      send_item(make_cmd(CMD_SPARE_HI, 1, 32'hFFFF_FFFF, -5));
      // Block every awake thread on one semaphore until none is runnable, then release all
      send_item(make_cmd(CMD_INIT, 1, 32'd0, -6));
      repeat (6) send_item(make_cmd(CMD_WAIT, 1, 32'd0, 0));
      repeat (6) send_item(make_cmd(CMD_SIGNAL, 1, 32'd0, 0));
      wait_idle();

      // Short periods on both events
      program_events(32'd1, 32'd3, 32'd1, 32'd7);
      run_random(PHASE_ITEMS, -1, -1);

      // No idling on either side; event zero off with widest period
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_events(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1, 32'd1);
      run_random(PHASE_ITEMS, -1, -1);

      // Long result hold so the block backs up
      send_idle_pct = 40;
      recv_idle_pct = 40;
      program_events(32'hFFFF_FFFF, $urandom_range(1, 20), 32'd0, 32'd0);
      run_random(PHASE_ITEMS, 30, -1);

      // Sender pause mid-phase until everything has drained
      send_idle_pct = 60;
      recv_idle_pct = 60;
      program_events(32'd1, $urandom, 32'd1, $urandom_range(0, 5));
      run_random(PHASE_ITEMS, -1, 80);

      // Events off, random register contents
      program_events($urandom & 32'hFFFF_FFFE, $urandom, 32'd0, $urandom);
      run_random(PHASE_ITEMS, 100, 40);

      // Longest sleep last, as it parks a thread for good
      send_item(make_cmd(CMD_SLEEP, 4, 32'hFFFF_FFFF, 0));
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
